// ===== rtl/key_combo_sequence_detector_macros.svh =====
// ----------------------------------------------------------------------------
// key combo sequence detector assertion macros
// shared concurrent assertion forms for the detector checker
// ----------------------------------------------------------------------------
`ifndef KEY_COMBO_SEQUENCE_DETECTOR_MACROS_SVH
`define KEY_COMBO_SEQUENCE_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define KCSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcsd assertion failed");

// next-cycle implication, disabled during reset
`define KCSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcsd assertion failed");

`endif

// ===== rtl/kcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// kcsd package
// types, constants and helpers of the key combo sequence detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcsd_pkg;

  localparam int MAX_STEPS  = 8;
  localparam int STEP_IDX_W = $clog2(MAX_STEPS);
  localparam int KEY_W      = 8;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 4;
  localparam int TIME_W     = 32;
  localparam int DT_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [TIME_W-1:0] TIME_LIMIT_RST = TIME_W'(1000);

  typedef enum logic [1:0] {
    REQ_PRESS   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_RESTART = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_MASKS   = 2'd0,
    CFG_STEP_COUNT   = 2'd1,
    CFG_TIME_LIMIT   = 2'd2,
    CFG_AUTO_RESTART = 2'd3
  } cfg_index_t;

  typedef logic [MAX_STEPS-1:0][KEY_W-1:0] mask_arr_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [KEY_W-1:0]  key_bits;
    logic [DT_W-1:0]   time_step;
  } kcsd_req_t;

  typedef struct packed {
    mask_arr_t         step_masks;
    logic [CNT_W-1:0]  step_count;
    logic [TIME_W-1:0] time_limit;
    logic              auto_restart;
  } kcsd_cfg_t;

  typedef struct packed {
    logic              matched;
    logic [POS_W-1:0]  step_position;
    logic [KEY_W-1:0]  held_keys;
  } kcsd_res_t;

  // step count clamped to the sequence length
  function automatic logic [POS_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    if (cnt > CNT_W'(MAX_STEPS)) begin
      return POS_W'(MAX_STEPS);
    end
    return POS_W'(cnt);
  endfunction

  // key mask of one step, zero past the end of the sequence
  function automatic logic [KEY_W-1:0] mask_at(input mask_arr_t masks,
                                               input logic [POS_W-1:0] pos,
                                               input logic [POS_W-1:0] eff);
    if (pos >= eff) begin
      return '0;
    end
    return masks[pos[STEP_IDX_W-1:0]];
  endfunction

endpackage

// ===== rtl/kcsd_core.sv =====
// ----------------------------------------------------------------------------
// kcsd core
// held-key, elapsed-time and position state with its per-request update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcsd_core
  import kcsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  kcsd_req_t req,
  input  kcsd_cfg_t cfg,
  output kcsd_res_t res_nxt
);

  logic [KEY_W-1:0]  held_r, held_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic [POS_W-1:0]  eff;
  logic              matched0;
  logic [TIME_W-1:0] e1, e2, e3;
  logic [POS_W-1:0]  p1, p2;
  logic [TIME_W:0]   sum;
  logic [KEY_W-1:0]  cur, prev, step0;
  logic              stray;

  // tick datapath
  always_comb begin
    eff      = eff_count(cfg.step_count);
    matched0 = (pos_r >= eff);
    e1       = matched0 ? '0 : elapsed_r;
    p1       = matched0 ? '0 : pos_r;
    sum      = {1'b0, e1} + (TIME_W+1)'(req.time_step);
    e2       = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    e3       = (e2 > cfg.time_limit) ? '0 : e2;
    p2       = (e2 > cfg.time_limit) ? '0 : p1;
    cur      = mask_at(cfg.step_masks, p2, eff);
    prev     = (p2 == '0 || p2 >= eff) ? '0
             : mask_at(cfg.step_masks, p2 - POS_W'(1), eff);
    step0    = mask_at(cfg.step_masks, '0, eff);
    stray    = |(held_r & ~(cur | prev));
  end

  always_comb begin
    held_nxt    = held_r;
    elapsed_nxt = elapsed_r;
    pos_nxt     = pos_r;
    unique case (req.req_type)
      REQ_PRESS:   held_nxt = held_r | req.key_bits;
      REQ_RELEASE: held_nxt = held_r & ~req.key_bits;
      REQ_RESTART: begin
        elapsed_nxt = '0;
        pos_nxt     = '0;
      end
      REQ_TICK: begin
        if (matched0 && !cfg.auto_restart) begin
          // match held, tick ignored
          elapsed_nxt = elapsed_r;
          pos_nxt     = pos_r;
        end else if (p2 >= eff) begin
          elapsed_nxt = e3;
          pos_nxt     = p2;
        end else if (held_r == cur) begin
          elapsed_nxt = e3;
          pos_nxt     = p2 + POS_W'(1);
        end else if (stray) begin
          elapsed_nxt = '0;
          pos_nxt     = (held_r == step0) ? POS_W'(1) : '0;
        end else begin
          elapsed_nxt = e3;
          pos_nxt     = p2;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt.matched       = (pos_nxt >= eff);
    res_nxt.step_position = pos_nxt;
    res_nxt.held_keys     = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      elapsed_r <= '0;
      pos_r     <= '0;
    end else if (fire) begin
      held_r    <= held_nxt;
      elapsed_r <= elapsed_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

// ===== rtl/key_combo_sequence_detector.sv =====
// ----------------------------------------------------------------------------
// key combo sequence detector
// tracks held keys and steps through a configured sequence of key masks
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in       | in_valid/in_ready  | in_req_type, in_key_bits, in_time_step
//  out      | out_valid/out_ready| out_matched, out_step_position,
//           |                    | out_held_keys
//  cfg      | cfg_wr_en          | cfg_index, cfg_wdata
//
//  one request per cycle sustained unless the result stalls; each passes the
//  input then result register, via the single update pass in kcsd_core
//  synchronous active-low reset clears state and config to defaults
//  a stalled result holds the result register; the input register still
//  takes a request until it too is full, then in_ready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_combo_sequence_detector
  import kcsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [KEY_W-1:0]      in_key_bits,
  input  logic [DT_W-1:0]       in_time_step,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_matched,
  output logic [POS_W-1:0]      out_step_position,
  output logic [KEY_W-1:0]      out_held_keys,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  kcsd_cfg_t cfg_r;

  // input register stage
  logic      s1_vld_r;
  kcsd_req_t s1_req_r;

  // result register stage
  logic      out_vld_r;
  kcsd_res_t out_res_r;
  kcsd_res_t res_nxt;

  logic      out_free;
  logic      advance;
  logic      in_fire;

  // the result register frees when empty or being taken this cycle
  assign out_free = !out_vld_r || out_ready;
  // request in stage one is processed and state updated on advance
  assign advance  = s1_vld_r && out_free;
  // stage one takes a new request when empty or moving on
  assign in_ready = !s1_vld_r || advance;
  assign in_fire  = in_valid && in_ready;

  // configuration registers, to be written by the user only while idle; the block itself has no guard for it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_masks   <= '0;
      cfg_r.step_count   <= '0;
      cfg_r.time_limit   <= TIME_LIMIT_RST;
      cfg_r.auto_restart <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_STEP_MASKS:   cfg_r.step_masks   <= mask_arr_t'(cfg_wdata);
        CFG_STEP_COUNT:   cfg_r.step_count   <= cfg_wdata[CNT_W-1:0];
        CFG_TIME_LIMIT:   cfg_r.time_limit   <= cfg_wdata[TIME_W-1:0];
        CFG_AUTO_RESTART: cfg_r.auto_restart <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.req_type  <= req_type_t'(in_req_type);
      s1_req_r.key_bits  <= in_key_bits;
      s1_req_r.time_step <= in_time_step;
    end
  end

  // state and update logic
  kcsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .req     (s1_req_r),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_matched       = out_res_r.matched;
  assign out_step_position = out_res_r.step_position;
  assign out_held_keys     = out_res_r.held_keys;

endmodule

// ===== rtl/kcsd_checker.sv =====
// ----------------------------------------------------------------------------
// kcsd checker
// port-level assertions on the key combo sequence detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_combo_sequence_detector_macros.svh"

module kcsd_checker
  import kcsd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_matched,
  input logic [POS_W-1:0]      out_step_position,
  input logic [KEY_W-1:0]      out_held_keys
);

  logic [KEY_W+POS_W:0] out_pay;

  assign out_pay = {out_matched, out_step_position, out_held_keys};

  // a stalled result stays put
  `KCSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pay))

  // backpressure on requests only comes from a stalled result
  `KCSD_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready)

  // an accepted request has a result showing once past the input and result registers
  `KCSD_ASSERT_NEXT(a_latency, in_valid && in_ready, ##1 out_valid)

  // position never runs past the longest sequence
  `KCSD_ASSERT_NOW(a_pos_range, out_valid, out_step_position <= POS_W'(MAX_STEPS))

endmodule

bind key_combo_sequence_detector kcsd_checker u_kcsd_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// key combo sequence detector testbench
// drives press, release, tick and restart requests through the request
// channel, tracks held keys, elapsed time and sequence position in a
// shadow of the detector, and checks every result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import kcsd_pkg::*;

  // kinds of rows in the directed script
  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    req_type_t         req;
    logic [KEY_W-1:0]  keys;
    logic [DT_W-1:0]   dt;
    cfg_index_t        reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    bit                typed;   // status written out by hand in the script
    kcsd_res_t         want;
  } combo_row_t;

  localparam int RAND_PHASES    = 8;
  localparam int REQS_PER_PHASE = 112;
  localparam int SAT_TICKS      = 16;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_SHOWN      = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_req_type = '0;
  logic [KEY_W-1:0]      in_key_bits = '0;
  logic [DT_W-1:0]       in_time_step = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_matched;
  logic [POS_W-1:0]      out_step_position;
  logic [KEY_W-1:0]      out_held_keys;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the configuration registers
  logic [CFG_DATA_W-1:0] sh_masks;
  logic [CNT_W-1:0]      sh_count;
  logic [TIME_W-1:0]     sh_limit;
  logic                  sh_auto;
  // shadow of the detector state
  logic [KEY_W-1:0]      sh_held;
  logic [TIME_W-1:0]     sh_elapsed;
  logic [POS_W-1:0]      sh_pos;

  kcsd_res_t  combo_status_q[$];   // status due for each accepted request
  kcsd_res_t  got_status;
  kcsd_res_t  due_status;
  int         status_errs = 0;
  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  combo_row_t script[$];

  key_combo_sequence_detector DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_key_bits       (in_key_bits),
    .in_time_step      (in_time_step),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_matched       (out_matched),
    .out_step_position (out_step_position),
    .out_held_keys     (out_held_keys),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow detector
  // ---------------------------------------------------------------------------

  // steps in use, a count above the array size means the whole array
  function automatic logic [POS_W-1:0] seq_len();
    return (sh_count > CNT_W'(MAX_STEPS)) ? POS_W'(MAX_STEPS) : POS_W'(sh_count);
  endfunction

  // key mask of a step, zero once past the sequence end
  function automatic logic [KEY_W-1:0] step_mask(input logic [POS_W-1:0] idx);
    if (idx >= seq_len()) begin
      return '0;
    end
    return sh_masks[8 * idx[STEP_IDX_W-1:0] +: KEY_W];
  endfunction

  // mask of the step just passed, zero at the start or when complete
  function automatic logic [KEY_W-1:0] prev_step_mask();
    if (sh_pos == '0 || sh_pos >= seq_len()) begin
      return '0;
    end
    return step_mask(sh_pos - 1'b1);
  endfunction

  function automatic void restart_combo();
    sh_elapsed = '0;
    sh_pos     = '0;
  endfunction

  function automatic void tick_combo(input logic [DT_W-1:0] dt);
    logic [TIME_W:0]  sum;
    logic [KEY_W-1:0] both;
    // a finished sequence either rearms or holds until restarted
    if (sh_pos >= seq_len()) begin
      if (sh_auto) begin
        restart_combo();
      end else begin
        return;
      end
    end
    // elapsed time sticks at all ones
    sum = {1'b0, sh_elapsed} + (TIME_W + 1)'(dt);
    sh_elapsed = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    if (sh_elapsed > sh_limit) begin
      restart_combo();
    end
    if (sh_pos >= seq_len()) begin
      return;
    end
    if (sh_held == step_mask(sh_pos)) begin
      sh_pos = sh_pos + 1'b1;
      return;
    end
    // a stray key drops back to the start, which may match step zero at once
    both = step_mask(sh_pos) | prev_step_mask();
    if ((sh_held & ~both) != '0) begin
      restart_combo();
      if (sh_held == step_mask(sh_pos)) begin
        sh_pos = sh_pos + 1'b1;
      end
    end
  endfunction

  // applies one request to the shadow and returns the status it reports
  function automatic kcsd_res_t track_combo(input req_type_t req,
                                            input logic [KEY_W-1:0] keys,
                                            input logic [DT_W-1:0] dt);
    kcsd_res_t st;
    case (req)
      REQ_PRESS:   sh_held = sh_held | keys;
      REQ_RELEASE: sh_held = sh_held & ~keys;
      REQ_TICK:    tick_combo(dt);
      REQ_RESTART: restart_combo();
    endcase
    st.matched       = (sh_pos >= seq_len());
    st.step_position = sh_pos;
    st.held_keys     = sh_held;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // script rows
  // ---------------------------------------------------------------------------

  function automatic combo_row_t req_row(input req_type_t req,
                                         input logic [KEY_W-1:0] keys,
                                         input logic [DT_W-1:0] dt);
    combo_row_t r;
    r.kind    = ROW_REQ;
    r.req     = req;
    r.keys    = keys;
    r.dt      = dt;
    r.reg_idx = CFG_STEP_MASKS;
    r.wdata   = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  // request whose status is plain from the spec
  function automatic combo_row_t chk_row(input req_type_t req,
                                         input logic [KEY_W-1:0] keys,
                                         input logic [DT_W-1:0] dt,
                                         input logic m,
                                         input logic [POS_W-1:0] pos,
                                         input logic [KEY_W-1:0] held);
    combo_row_t r;
    r = req_row(req, keys, dt);
    r.typed              = 1'b1;
    r.want.matched       = m;
    r.want.step_position = pos;
    r.want.held_keys     = held;
    return r;
  endfunction

  function automatic combo_row_t cfg_row(input cfg_index_t idx,
                                         input logic [CFG_DATA_W-1:0] val);
    combo_row_t r;
    r = req_row(REQ_PRESS, '0, '0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.wdata   = val;
    return r;
  endfunction

  // appends one row to the end of the script
  function automatic void add_row(input combo_row_t r);
    script.insert(script.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one request: hold it until taken, log its status, then maybe go idle
  task automatic send_req(input req_type_t req, input logic [KEY_W-1:0] keys,
                          input logic [DT_W-1:0] dt, input bit typed,
                          input kcsd_res_t typed_status);
    kcsd_res_t st;
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_key_bits  <= keys;
    in_time_step <= dt;
    do @(posedge clk); while (!in_ready);
    st = track_combo(req, keys, dt);
    combo_status_q.insert(combo_status_q.size(), typed ? typed_status : st);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
  endtask

  // stop sending and let every pending status come back
  task automatic drain();
    in_valid <= 1'b0;
    while (combo_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever issued while the detector is empty
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_STEP_MASKS:   sh_masks = val;
      CFG_STEP_COUNT:   sh_count = val[CNT_W-1:0];
      CFG_TIME_LIMIT:   sh_limit = val[TIME_W-1:0];
      CFG_AUTO_RESTART: sh_auto  = val[0];
    endcase
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 47; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 47; end
      default: begin snd_idle_pct = 37; rcv_stall_pct = 37; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result side: check against the oldest pending status, then pick ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_status.matched       = out_matched;
      got_status.step_position = out_step_position;
      got_status.held_keys     = out_held_keys;
      if (combo_status_q.size() == 0) begin
        status_errs++;
        if (status_errs <= MAX_SHOWN) begin
          $display("unexpected result: matched=%0d pos=%0d held=%02h",
                   got_status.matched, got_status.step_position, got_status.held_keys);
        end
      end else begin
        due_status = combo_status_q.pop_front();
        if (got_status.matched !== due_status.matched ||
            got_status.step_position !== due_status.step_position ||
            got_status.held_keys !== due_status.held_keys) begin
          status_errs++;
          if (status_errs <= MAX_SHOWN) begin
            $display("status mismatch: expected matched=%0d pos=%0d held=%02h,",
                     due_status.matched, due_status.step_position,
                     due_status.held_keys);
            $display("  got matched=%0d pos=%0d held=%02h",
                     got_status.matched, got_status.step_position,
                     got_status.held_keys);
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [KEY_W-1:0] target;
    logic [KEY_W-1:0] keys;
    logic [DT_W-1:0]  dt;
    req_type_t        req;
    logic [CNT_W-1:0] cnt;
    logic [TIME_W-1:0] lim;
    logic [CFG_DATA_W-1:0] masks;

    // reset defaults of the shadow
    sh_masks   = '0;
    sh_count   = '0;
    sh_limit   = TIME_LIMIT_RST;
    sh_auto    = 1'b1;
    sh_held    = '0;
    sh_elapsed = '0;
    sh_pos     = '0;

    // directed script
    // empty sequence after reset: always matched, held mask still tracked
    add_row(chk_row(REQ_PRESS,   8'hFF, 16'h0000, 1'b1, 4'd0, 8'hFF));
    add_row(chk_row(REQ_RELEASE, 8'h0F, 16'hFFFF, 1'b1, 4'd0, 8'hF0));
    add_row(chk_row(REQ_TICK,    8'h00, 16'hFFFF, 1'b1, 4'd0, 8'hF0));
    // restart keeps the held keys
    add_row(chk_row(REQ_RESTART, 8'hFF, 16'h0000, 1'b1, 4'd0, 8'hF0));
    add_row(chk_row(REQ_RELEASE, 8'hFF, 16'h0000, 1'b1, 4'd0, 8'h00));
    // three-step combo 01, 03, 02 with no timeout and the match held
    add_row(cfg_row(CFG_STEP_MASKS,   64'h80_20_10_08_04_02_03_01));
    add_row(cfg_row(CFG_STEP_COUNT,   64'd3));
    add_row(cfg_row(CFG_TIME_LIMIT,   64'hFFFF_FFFF));
    add_row(cfg_row(CFG_AUTO_RESTART, 64'd0));
    add_row(req_row(REQ_PRESS,   8'h01, 16'h0000));
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));
    add_row(req_row(REQ_PRESS,   8'h02, 16'h0000));
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));
    // stray key outside current and previous steps
    add_row(req_row(REQ_PRESS,   8'h80, 16'h0000));
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));
    add_row(req_row(REQ_RELEASE, 8'h82, 16'h0000));
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));
    add_row(req_row(REQ_PRESS,   8'h02, 16'h0000));
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));
    add_row(req_row(REQ_RELEASE, 8'h01, 16'h0000));
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));
    // match held while auto restart is off
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));
    // step count lowered under the position
    add_row(cfg_row(CFG_STEP_COUNT,   64'd1));
    add_row(req_row(REQ_PRESS,   8'h00, 16'h0000));
    // oversized count acts as eight steps, short timeout
    add_row(cfg_row(CFG_AUTO_RESTART, 64'd1));
    add_row(cfg_row(CFG_TIME_LIMIT,   64'd5));
    add_row(cfg_row(CFG_STEP_COUNT,   64'd15));
    add_row(req_row(REQ_TICK,    8'h00, 16'd3));
    add_row(req_row(REQ_TICK,    8'h00, 16'd3));
    // single step with auto restart rearming on the next tick
    add_row(cfg_row(CFG_STEP_COUNT,   64'd1));
    add_row(req_row(REQ_RELEASE, 8'h02, 16'h0000));
    add_row(req_row(REQ_PRESS,   8'h01, 16'h0000));
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));
    add_row(req_row(REQ_TICK,    8'h00, 16'h0000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0);
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain();
        write_reg(script[i].reg_idx, script[i].wdata);
      end else begin
        send_req(script[i].req, script[i].keys, script[i].dt,
                 script[i].typed, script[i].want);
      end
    end

    // random phases, each with its own register setting and idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      masks = {$urandom, $urandom};
      case (ph)
        0: begin cnt = 4'd8;  lim = 32'd200;       end
        1: begin cnt = 4'd0;  lim = TIME_LIMIT_RST; end
        2: begin cnt = 4'd15; lim = 32'hFFFF_FFFF; masks = '1; end
        3: begin cnt = 4'd1;  lim = 32'd0;         masks = '0; end
        default: begin
          cnt = CNT_W'($urandom_range(2, 15));
          lim = $urandom_range(20, 400);
        end
      endcase
      write_reg(CFG_STEP_MASKS, masks);
      write_reg(CFG_STEP_COUNT, CFG_DATA_W'(cnt));
      write_reg(CFG_TIME_LIMIT, CFG_DATA_W'(lim));
      write_reg(CFG_AUTO_RESTART, CFG_DATA_W'(ph % 3 != 1));
      set_idling(ph % 4);

      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        // tick length: mostly short, now and then huge
        case ($urandom_range(9))
          0, 1, 2: dt = '0;
          8:       dt = DT_W'($urandom_range(0, 65535));
          9:       dt = '1;
          default: dt = DT_W'($urandom_range(1, 40));
        endcase
        target = (sh_pos < seq_len()) ? step_mask(sh_pos) : KEY_W'($urandom);
        if ($urandom_range(99) < 75) begin
          // walk the held keys toward the step in front, then tick
          if ((sh_held & ~target) != '0) begin
            keys = (sh_held & ~target) | (KEY_W'($urandom) & ~target);
            send_req(REQ_RELEASE, keys, DT_W'($urandom), 1'b0, '0);
          end else if ((target & ~sh_held) != '0) begin
            send_req(REQ_PRESS, target & ~sh_held, DT_W'($urandom), 1'b0, '0);
          end else begin
            send_req(REQ_TICK, KEY_W'($urandom), dt, 1'b0, '0);
          end
        end else begin
          // noise of any kind
          req  = req_type_t'($urandom_range(0, 3));
          keys = KEY_W'($urandom);
          send_req(req, keys, ($urandom_range(1) != 0) ? dt : DT_W'($urandom), 1'b0, '0);
        end
      end
    end

    // large elapsed: park at step one with no timeout and pile up big ticks,
    // then a limit one below all ones must still not fire
    drain();
    set_idling(0);
    write_reg(CFG_STEP_MASKS,   64'h00_00_00_00_00_00_06_01);
    write_reg(CFG_STEP_COUNT,   64'd2);
    write_reg(CFG_TIME_LIMIT,   64'hFFFF_FFFF);
    write_reg(CFG_AUTO_RESTART, 64'd0);
    send_req(REQ_RESTART, 8'h00, 16'h0000, 1'b0, '0);
    send_req(REQ_RELEASE, 8'hFF, 16'h0000, 1'b0, '0);
    send_req(REQ_PRESS,   8'h01, 16'h0000, 1'b0, '0);
    send_req(REQ_TICK,    8'h00, 16'h0000, 1'b0, '0);
    send_req(REQ_PRESS,   8'h02, 16'h0000, 1'b0, '0);
    for (int n = 0; n < SAT_TICKS; n++) begin
      send_req(REQ_TICK, 8'h00, 16'hFFFF, 1'b0, '0);
    end
    drain();
    write_reg(CFG_TIME_LIMIT, 64'hFFFF_FFFE);
    send_req(REQ_TICK, 8'h00, 16'h0000, 1'b0, '0);

    // let the tail drain, then wait on to catch stray results
    drain();
    repeat (8) @(posedge clk);
    if (status_errs == 0 && combo_status_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
